// ===== rtl/core/shv_pkg.sv =====
// Shared types and constants of the stack height validator.
// No dependencies; imported by every module of the block but shv_fifo.
`default_nettype none

package shv_pkg;

  // Internal height width; heights saturate at the top of this range
  localparam int unsigned SHV_HW = 32;

  // Opcodes
  localparam logic [7:0] OP_PUSH_A = 8'd0;
  localparam logic [7:0] OP_PUSH_B = 8'd1;
  localparam logic [7:0] OP_PEEK   = 8'd2;
  localparam logic [7:0] OP_RET    = 8'd3;
  localparam logic [7:0] OP_POP_A  = 8'd4;
  localparam logic [7:0] OP_POP_B  = 8'd5;
  localparam logic [7:0] OP_BIN_A  = 8'd6;
  localparam logic [7:0] OP_BIN_B  = 8'd7;
  localparam logic [7:0] OP_IF     = 8'd8;
  localparam logic [7:0] OP_CALL   = 8'd9;
  localparam logic [7:0] OP_SCOPE  = 8'd10;
  localparam logic [7:0] OP_ELSE   = 8'd11;
  localparam logic [7:0] OP_END    = 8'd12;
  localparam logic [7:0] OP_NOP    = 8'd13;
  localparam logic [7:0] OP_HALT   = 8'd14;

  // Control frame kinds
  localparam logic KIND_BLOCK = 1'b0;
  localparam logic KIND_IF    = 1'b1;

  typedef enum logic [1:0] {
    REQ_START = 2'd0,
    REQ_INSTR = 2'd1,
    REQ_END   = 2'd2,
    REQ_NONE  = 2'd3
  } shv_req_e;

  typedef enum logic [2:0] {
    CLS_PLAIN = 3'd0,
    CLS_BLOCK = 3'd1,
    CLS_IF    = 3'd2,
    CLS_ELSE  = 3'd3,
    CLS_END   = 3'd4,
    CLS_RET   = 3'd5,
    CLS_BAD   = 3'd6
  } shv_cls_e;

  typedef enum logic [3:0] {
    ERR_NONE      = 4'd0,
    ERR_UNDERFLOW = 4'd1,
    ERR_ELSE      = 4'd2,
    ERR_END       = 4'd3,
    ERR_BLOCK_H   = 4'd4,
    ERR_IF_H      = 4'd5,
    ERR_UNCLOSED  = 4'd6,
    ERR_FINAL_H   = 4'd7,
    ERR_CTL_OVF   = 4'd8,
    ERR_BAD_OP    = 4'd9
  } shv_err_e;

  // Decoded item as it travels from the front to the back
  typedef struct packed {
    shv_req_e    req;
    shv_cls_e    cls;
    logic [16:0] need;  // operands required on the stack
    logic [15:0] sub;   // operands removed
    logic        inc;   // one operand added
  } shv_item_t;

  // One control stack frame
  typedef struct packed {
    logic              kind;
    logic [SHV_HW-1:0] entry_h;
    logic              entry_live;
    logic              then_seen;
    logic              then_live;
    logic [SHV_HW-1:0] then_h;
  } shv_frame_t;

endpackage

`default_nettype wire

// ===== rtl/core/shv_fifo.sv =====
// Two-entry queue with independent write and read sides.
// No package dependencies; used between front and back and on the result side.
`default_nettype none

module shv_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             wr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             rd_i,
  output logic [WIDTH-1:0]      rdata_o,
  output logic                  empty_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wp_q, wp_d, rp_q, rp_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             do_wr, do_rd;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rp_q];

  // Advance pointers and fill count
  always_comb begin
    wp_d  = do_wr ? !wp_q : wp_q;
    rp_d  = do_rd ? !rp_q : rp_q;
    cnt_d = cnt_q;
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  // Hold entries
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wp_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/shv_front.sv =====
// Front part: takes items from the input side and classifies each opcode.
// Depends on shv_pkg; feeds the decoupling queue.
`default_nettype none

module shv_front
  import shv_pkg::*;
(
  input  wire logic        push_i,
  input  wire logic        q_full_i,
  input  wire logic [1:0]  req_type_i,
  input  wire logic [7:0]  opcode_i,
  input  wire logic [15:0] arg_i,
  output logic             q_wr_o,
  output shv_item_t        q_item_o
);

  shv_req_e req;

  assign req = shv_req_e'(req_type_i);

  // Drop requests of unknown type; they have no effect
  assign q_wr_o = push_i && !q_full_i && (req != REQ_NONE);

  // Classify the opcode and its operand demand
  always_comb begin
    q_item_o      = '0;
    q_item_o.req  = req;
    q_item_o.cls  = CLS_PLAIN;
    q_item_o.need = 17'd0;
    q_item_o.sub  = 16'd0;
    q_item_o.inc  = 1'b0;
    unique case (opcode_i)
      OP_PUSH_A, OP_PUSH_B: q_item_o.inc = 1'b1;
      OP_PEEK:              q_item_o.need = 17'd1;
      OP_RET: begin
        q_item_o.cls  = CLS_RET;
        q_item_o.need = 17'd1;
      end
      OP_POP_A, OP_POP_B: begin
        q_item_o.need = 17'd1;
        q_item_o.sub  = 16'd1;
      end
      OP_BIN_A, OP_BIN_B: begin
        q_item_o.need = 17'd2;
        q_item_o.sub  = 16'd1;
      end
      OP_IF:    q_item_o.cls = CLS_IF;
      OP_CALL: begin
        q_item_o.need = {1'b0, arg_i} + 17'd1;
        q_item_o.sub  = arg_i;
      end
      OP_SCOPE: q_item_o.cls = CLS_BLOCK;
      OP_ELSE:  q_item_o.cls = CLS_ELSE;
      OP_END:   q_item_o.cls = CLS_END;
      OP_NOP, OP_HALT: q_item_o.cls = CLS_PLAIN;
      default:  q_item_o.cls = CLS_BAD;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/shv_back.sv =====
// Back part: tracks height, reachability and the control stack, keeps the
// first error and forms the verdict on region end. Depends on shv_pkg.
`default_nettype none

module shv_back
  import shv_pkg::*;
#(
  parameter int unsigned CTL_DEPTH   = 256,
  parameter int unsigned HEIGHT_BITS = 16,
  parameter int unsigned PC_BITS     = 16,
  parameter int unsigned REGION_BITS = 8
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  input  wire shv_item_t              in_item_i,
  input  wire logic [PC_BITS-1:0]     in_pc_i,
  output logic                        in_ready_o,
  input  wire logic                   res_full_i,
  output logic                        res_push_o,
  output logic                        res_valid_o,
  output shv_err_e                    res_code_o,
  output logic signed [PC_BITS:0]     res_pc_o,
  output logic signed [REGION_BITS:0] res_region_o,
  output logic [HEIGHT_BITS-1:0]      res_peak_o,
  output logic [HEIGHT_BITS-1:0]      res_final_o
);

  localparam int unsigned DW = $clog2(CTL_DEPTH + 1);
  localparam int unsigned IW = $clog2(CTL_DEPTH);
  localparam logic [SHV_HW:0] HMAX = ({{SHV_HW{1'b0}}, 1'b1} << HEIGHT_BITS) - 1'b1;

  // Frames below the top of the control stack
  shv_frame_t ctl_mem [CTL_DEPTH];

  logic [SHV_HW-1:0]        h_q, h_d, peak_q, peak_d, peak_eff;
  logic                     reach_q, reach_d, stop_q, stop_d, has_q, has_d;
  logic [DW-1:0]            depth_q, depth_d;
  shv_frame_t               top_q, top_d, below_q;
  logic [REGION_BITS-1:0]   rgn_q, rgn_d;
  logic [PC_BITS-1:0]       lpc_q, lpc_d, fpc;
  shv_err_e                 ecode_q, ecode_n, fcode;
  logic signed [PC_BITS:0]  epc_q, epc_n;
  logic signed [REGION_BITS:0] ereg_q, ereg_n;
  logic                     go, clr_prog, do_push, do_pop, push_req, push_kind;
  logic                     ctl_full, commit;
  logic                     tl, el;
  logic [SHV_HW-1:0]        th, eh;
  logic [IW-1:0]            wr_idx, rd_idx;

  assign in_ready_o = !((in_item_i.req == REQ_END) && res_full_i);
  assign go         = in_valid_i && in_ready_o;
  assign ctl_full   = (depth_q >= DW'(CTL_DEPTH));
  assign wr_idx     = IW'(depth_q - DW'(1));
  assign rd_idx     = IW'(depth_q - DW'(3));

  // Branch join terms for an if frame on the top
  assign tl = top_q.then_seen ? top_q.then_live : top_q.entry_live;
  assign th = top_q.then_seen ? top_q.then_h : top_q.entry_h;
  assign el = reach_q;
  assign eh = reach_q ? h_q : '0;

  // Execute one item
  always_comb begin
    h_d       = h_q;
    reach_d   = reach_q;
    stop_d    = stop_q;
    depth_d   = depth_q;
    top_d     = top_q;
    rgn_d     = rgn_q;
    lpc_d     = lpc_q;
    has_d     = has_q;
    fcode     = ERR_NONE;
    fpc       = in_pc_i;
    do_push   = 1'b0;
    do_pop    = 1'b0;
    push_req  = 1'b0;
    push_kind = KIND_BLOCK;
    clr_prog  = 1'b0;
    res_push_o = 1'b0;
    if (go) begin
      unique case (in_item_i.req)
        REQ_START: begin
          clr_prog = 1'b1;
          depth_d  = '0;
          h_d      = '0;
          reach_d  = 1'b1;
          stop_d   = 1'b0;
          lpc_d    = '0;
          has_d    = 1'b0;
          rgn_d    = '0;
        end
        REQ_INSTR: begin
          if (!stop_q) begin
            lpc_d = in_pc_i;
            has_d = 1'b1;
            unique case (in_item_i.cls)
              CLS_BLOCK: push_req = 1'b1;
              CLS_IF: begin
                if (reach_q) begin
                  if (h_q == '0) begin
                    fcode   = ERR_UNDERFLOW;
                    reach_d = 1'b0;
                  end else begin
                    h_d = h_q - 1'b1;
                  end
                end
                push_req  = 1'b1;
                push_kind = KIND_IF;
              end
              CLS_ELSE: begin
                if (depth_q == '0 || top_q.kind != KIND_IF) begin
                  fcode   = ERR_ELSE;
                  reach_d = 1'b0;
                end else begin
                  top_d.then_seen = 1'b1;
                  top_d.then_live = reach_q;
                  top_d.then_h    = reach_q ? h_q : '0;
                  reach_d         = top_q.entry_live;
                  h_d             = top_q.entry_h;
                end
              end
              CLS_END: begin
                if (depth_q == '0) begin
                  fcode   = ERR_END;
                  reach_d = 1'b0;
                end else begin
                  do_pop  = 1'b1;
                  depth_d = depth_q - 1'b1;
                  top_d   = below_q;
                  if (top_q.kind == KIND_BLOCK) begin
                    if (top_q.entry_live && reach_q && h_q != top_q.entry_h) begin
                      fcode   = ERR_BLOCK_H;
                      reach_d = 1'b0;
                    end
                  end else if (tl && el && th != eh) begin
                    fcode   = ERR_IF_H;
                    reach_d = 1'b0;
                  end else if (tl) begin
                    reach_d = 1'b1;
                    h_d     = th;
                  end else if (el) begin
                    reach_d = 1'b1;
                    h_d     = eh;
                  end else begin
                    reach_d = 1'b0;
                    h_d     = top_q.entry_h;
                  end
                end
              end
              CLS_RET: begin
                if (reach_q) begin
                  reach_d = 1'b0;
                  if (h_q == '0) begin
                    fcode = ERR_UNDERFLOW;
                  end else begin
                    h_d = h_q - 1'b1;
                  end
                end
              end
              CLS_BAD: begin
                fcode   = ERR_BAD_OP;
                reach_d = 1'b0;
              end
              CLS_PLAIN: begin
                if (reach_q) begin
                  if (h_q < {{(SHV_HW-17){1'b0}}, in_item_i.need}) begin
                    fcode   = ERR_UNDERFLOW;
                    reach_d = 1'b0;
                  end else if (in_item_i.inc) begin
                    if (h_q != '1) begin
                      h_d = h_q + 1'b1;
                    end
                  end else begin
                    h_d = h_q - {{(SHV_HW-16){1'b0}}, in_item_i.sub};
                  end
                end
              end
              default: ;
            endcase
            // Open a frame, or stop the region on overflow
            if (push_req) begin
              if (ctl_full) begin
                if (fcode == ERR_NONE) begin
                  fcode = ERR_CTL_OVF;
                end
                reach_d = 1'b0;
                stop_d  = 1'b1;
              end else begin
                do_push          = 1'b1;
                depth_d          = depth_q + 1'b1;
                top_d.kind       = push_kind;
                top_d.entry_h    = h_d;
                top_d.entry_live = reach_d;
                top_d.then_seen  = 1'b0;
                top_d.then_live  = 1'b0;
                top_d.then_h     = '0;
              end
            end
          end
        end
        REQ_END: begin
          if (depth_q != '0) begin
            fcode = ERR_UNCLOSED;
          end
          if (reach_q && h_q != '0 && fcode == ERR_NONE) begin
            fcode = ERR_FINAL_H;
            fpc   = has_q ? lpc_q : in_pc_i;
          end
          res_push_o = 1'b1;
          rgn_d      = rgn_q + REGION_BITS'(1);
          depth_d    = '0;
          h_d        = '0;
          reach_d    = 1'b1;
          stop_d     = 1'b0;
          lpc_d      = '0;
          has_d      = 1'b0;
        end
        default: ;
      endcase
    end
  end

  // Keep only the first error of a program
  assign commit  = (ecode_q == ERR_NONE) && (fcode != ERR_NONE);
  assign ecode_n = commit ? fcode : ecode_q;
  assign epc_n   = commit ? signed'({1'b0, fpc}) : epc_q;
  assign ereg_n  = commit ? signed'({1'b0, rgn_q}) : ereg_q;

  // Fold the height left by the previous item into the peak
  assign peak_eff = (reach_q && h_q > peak_q) ? h_q : peak_q;
  assign peak_d   = clr_prog ? '0 : peak_eff;

  // Verdict of a region end
  assign res_valid_o  = (ecode_n == ERR_NONE);
  assign res_code_o   = ecode_n;
  assign res_pc_o     = epc_n;
  assign res_region_o = ereg_n;
  assign res_peak_o   = ({1'b0, peak_eff} > HMAX) ? HMAX[HEIGHT_BITS-1:0]
                                                  : peak_eff[HEIGHT_BITS-1:0];
  assign res_final_o  = ({1'b0, h_q} > HMAX) ? HMAX[HEIGHT_BITS-1:0]
                                             : h_q[HEIGHT_BITS-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q     <= '0;
      reach_q <= 1'b1;
      stop_q  <= 1'b0;
      depth_q <= '0;
      peak_q  <= '0;
      ecode_q <= ERR_NONE;
      epc_q   <= '1;
      ereg_q  <= '1;
      rgn_q   <= '0;
      lpc_q   <= '0;
      has_q   <= 1'b0;
    end else begin
      h_q     <= h_d;
      reach_q <= reach_d;
      stop_q  <= stop_d;
      depth_q <= depth_d;
      peak_q  <= peak_d;
      rgn_q   <= rgn_d;
      lpc_q   <= lpc_d;
      has_q   <= has_d;
      if (clr_prog) begin
        ecode_q <= ERR_NONE;
        epc_q   <= '1;
        ereg_q  <= '1;
      end else begin
        ecode_q <= ecode_n;
        epc_q   <= epc_n;
        ereg_q  <= ereg_n;
      end
    end
  end

  // Hold the top frame
  always_ff @(posedge clk_i) begin
    top_q <= top_d;
  end

  // Spill the top frame on push, refill the frame below it on pop
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      if (depth_q != '0) begin
        ctl_mem[wr_idx] <= top_q;
      end
      below_q <= top_q;
    end else if (do_pop) begin
      below_q <= ctl_mem[rd_idx];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/stack_height_validator_unit.sv =====
// Stack height validator, top level: front decode, decoupling queue, back
// execute and result queue. Depends on shv_pkg, shv_front, shv_fifo, shv_back.
//
// The block takes one item per clock: a program start, one instruction or a
// region end, and checks the operand-stack height of a structured bytecode
// program. The front decodes an item combinationally in the cycle it is
// pushed and writes it into a two-entry queue at the accepting edge; the back
// executes it from the head of that queue, after any earlier item that still
// waits ahead of it, and later while a region end stalls. A region-end verdict
// enters the result queue at the edge that executes it and can be popped in
// the following cycle. The sustained rate is one item per cycle, set by the
// back's height and control stack update; the control stack keeps its top two
// frames in registers and every frame below the top in a memory with one
// write and one registered read per cycle. Only region ends stall, and only
// while the two-entry result queue is full.
// The control stack needs no clearing after reset.
`default_nettype none

module stack_height_validator_unit
  import shv_pkg::*;
#(
  parameter int unsigned CTL_DEPTH   = 256,
  parameter int unsigned HEIGHT_BITS = 16,
  parameter int unsigned PC_BITS     = 16,
  parameter int unsigned REGION_BITS = 8
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   push,
  output logic                        full,
  input  wire logic [1:0]             req_type_i,
  input  wire logic [7:0]             opcode_i,
  input  wire logic [15:0]            arg_i,
  input  wire logic [PC_BITS-1:0]     pc_i,
  output logic                        empty,
  input  wire logic                   pop,
  output logic                        valid_res_o,
  output logic [3:0]                  error_code_o,
  output logic signed [PC_BITS:0]     error_pc_o,
  output logic signed [REGION_BITS:0] error_region_o,
  output logic [HEIGHT_BITS-1:0]      peak_height_o,
  output logic [HEIGHT_BITS-1:0]      final_height_o
);

  localparam int unsigned QW = $bits(shv_item_t) + PC_BITS;
  localparam int unsigned OW = 1 + 4 + (PC_BITS + 1) + (REGION_BITS + 1) + 2 * HEIGHT_BITS;

  logic                        q_wr, q_full, q_empty, b_ready, b_go;
  shv_item_t                   f_item, b_item;
  logic [PC_BITS-1:0]          b_pc;
  logic [QW-1:0]               q_rdata;
  logic                        res_push, res_full, res_valid;
  shv_err_e                    res_code;
  logic signed [PC_BITS:0]     res_pc;
  logic signed [REGION_BITS:0] res_region;
  logic [HEIGHT_BITS-1:0]      res_peak, res_final;
  logic [OW-1:0]               o_rdata;

  // Decode items as they arrive
  shv_front u_front (
    .push_i     (push),
    .q_full_i   (q_full),
    .req_type_i (req_type_i),
    .opcode_i   (opcode_i),
    .arg_i      (arg_i),
    .q_wr_o     (q_wr),
    .q_item_o   (f_item)
  );

  assign full = q_full;

  // Decouple decode from execute
  shv_fifo #(.WIDTH(QW)) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (q_wr),
    .wdata_i ({f_item, pc_i}),
    .full_o  (q_full),
    .rd_i    (b_go),
    .rdata_o (q_rdata),
    .empty_o (q_empty)
  );

  assign {b_item, b_pc} = q_rdata;
  assign b_go           = !q_empty && b_ready;

  // Execute items
  shv_back #(
    .CTL_DEPTH   (CTL_DEPTH),
    .HEIGHT_BITS (HEIGHT_BITS),
    .PC_BITS     (PC_BITS),
    .REGION_BITS (REGION_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (!q_empty),
    .in_item_i    (b_item),
    .in_pc_i      (b_pc),
    .in_ready_o   (b_ready),
    .res_full_i   (res_full),
    .res_push_o   (res_push),
    .res_valid_o  (res_valid),
    .res_code_o   (res_code),
    .res_pc_o     (res_pc),
    .res_region_o (res_region),
    .res_peak_o   (res_peak),
    .res_final_o  (res_final)
  );

  // Hold verdicts until taken
  shv_fifo #(.WIDTH(OW)) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (res_push),
    .wdata_i ({res_valid, res_code, res_pc, res_region, res_peak, res_final}),
    .full_o  (res_full),
    .rd_i    (pop),
    .rdata_o (o_rdata),
    .empty_o (empty)
  );

  assign {valid_res_o, error_code_o, error_pc_o, error_region_o,
          peak_height_o, final_height_o} = o_rdata;

`ifndef ASSERT_OFF
  a_res_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> !res_full)
    else $error("verdict pushed into a full result queue");

  a_end_reports: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_go && b_item.req == REQ_END) |-> res_push)
    else $error("region end executed without a verdict");

  a_full_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(q_full) |-> $past(q_wr))
    else $error("command queue filled without a write");

  a_no_stray_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> (b_go && b_item.req == REQ_END))
    else $error("verdict without a region end");
`endif

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking testbench of stack_height_validator_unit: directed programs,
// long corner sequences and random structured bytecode, checked per region.
// Depends on shv_pkg and the stack_height_validator_unit RTL.
`default_nettype none

module tb_top;
  import shv_pkg::*;

  localparam int unsigned FRAMES     = 256;
  localparam int unsigned RAND_ITEMS = 700;
  localparam int unsigned TAIL_ITEMS = 300;
  localparam int unsigned DRAIN_CYC  = 16;

  typedef struct {
    shv_req_e    req;
    logic [7:0]  op;
    logic [15:0] arg;
    logic [15:0] pc;
    bit          hold;  // wait for all verdicts before sending
  } bc_item_t;

  typedef struct {
    logic               ok;
    logic [3:0]         code;
    logic signed [16:0] epc;
    logic signed [8:0]  ergn;
    logic [15:0]        peak;
    logic [15:0]        fin;
  } verdict_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic               push       = 1'b0;
  logic               full;
  logic [1:0]         req_type_i = REQ_NONE;
  logic [7:0]         opcode_i   = '0;
  logic [15:0]        arg_i      = '0;
  logic [15:0]        pc_i       = '0;
  logic               empty;
  logic               pop        = 1'b0;
  logic               valid_res_o;
  logic [3:0]         error_code_o;
  logic signed [16:0] error_pc_o;
  logic signed [8:0]  error_region_o;
  logic [15:0]        peak_height_o;
  logic [15:0]        final_height_o;

  stack_height_validator_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .req_type_i     (req_type_i),
    .opcode_i       (opcode_i),
    .arg_i          (arg_i),
    .pc_i           (pc_i),
    .empty          (empty),
    .pop            (pop),
    .valid_res_o    (valid_res_o),
    .error_code_o   (error_code_o),
    .error_pc_o     (error_pc_o),
    .error_region_o (error_region_o),
    .peak_height_o  (peak_height_o),
    .final_height_o (final_height_o)
  );

  bc_item_t item_q[$];
  verdict_t verdict_q[$];
  int       fault_count = 0;

  // ---------------------------------------------------------------------------
  // Height checker state: control frames, height, reachability, first error
  // ---------------------------------------------------------------------------
  logic        fr_kind      [FRAMES];
  logic [31:0] fr_entry_h   [FRAMES];
  bit          fr_entry_live[FRAMES];
  bit          fr_then_seen [FRAMES];
  bit          fr_then_live [FRAMES];
  logic [31:0] fr_then_h    [FRAMES];

  int unsigned        open_frames   = 0;
  logic [31:0]        stk_h         = '0;
  bit                 live          = 1'b1;
  bit                 region_halted = 1'b0;
  logic [31:0]        peak_h        = '0;
  shv_err_e           first_code    = ERR_NONE;
  logic signed [16:0] first_pc      = -17'sd1;
  logic signed [8:0]  first_region  = -9'sd1;
  logic [7:0]         region_no     = '0;
  logic [15:0]        last_pc       = '0;
  bit                 saw_instr     = 1'b0;

  function automatic void clear_region();
    open_frames   = 0;
    stk_h         = '0;
    live          = 1'b1;
    region_halted = 1'b0;
    last_pc       = '0;
    saw_instr     = 1'b0;
  endfunction

  function automatic void record_error(shv_err_e code, logic [15:0] pc);
    if (first_code == ERR_NONE) begin
      first_code   = code;
      first_pc     = {1'b0, pc};
      first_region = {1'b0, region_no};
    end
  endfunction

  function automatic logic [15:0] sat16(logic [31:0] h);
    return (h > 32'h0000_FFFF) ? 16'hFFFF : h[15:0];
  endfunction

  // Push a frame, or flag overflow and halt the region
  function automatic bit open_frame(logic kind, logic [15:0] pc);
    if (open_frames >= FRAMES) begin
      record_error(ERR_CTL_OVF, pc);
      live          = 1'b0;
      region_halted = 1'b1;
      return 1'b0;
    end
    fr_kind[open_frames]       = kind;
    fr_entry_h[open_frames]    = stk_h;
    fr_entry_live[open_frames] = live;
    fr_then_seen[open_frames]  = 1'b0;
    fr_then_live[open_frames]  = 1'b0;
    fr_then_h[open_frames]     = '0;
    open_frames++;
    return 1'b1;
  endfunction

  function automatic void exec_instr(logic [7:0] op, logic [15:0] argc, logic [15:0] pc);
    int unsigned top;
    bit          then_ok;
    bit          else_ok;
    logic [31:0] then_h;
    logic [31:0] else_h;
    logic [31:0] need;
    last_pc   = pc;
    saw_instr = 1'b1;
    if (op == OP_SCOPE) begin
      if (!open_frame(KIND_BLOCK, pc)) return;
    end else if (op == OP_IF) begin
      if (live) begin
        if (stk_h == 0) begin
          record_error(ERR_UNDERFLOW, pc);
          live = 1'b0;
        end else begin
          stk_h--;
        end
      end
      if (!open_frame(KIND_IF, pc)) return;
    end else if (op == OP_ELSE) begin
      if (open_frames == 0 || fr_kind[open_frames-1] != KIND_IF) begin
        record_error(ERR_ELSE, pc);
        live = 1'b0;
      end else begin
        // Save what the then-branch left, restart from the if entry
        top               = open_frames - 1;
        fr_then_seen[top] = 1'b1;
        fr_then_live[top] = live;
        fr_then_h[top]    = live ? stk_h : '0;
        live              = fr_entry_live[top];
        stk_h             = fr_entry_h[top];
      end
    end else if (op == OP_END) begin
      if (open_frames == 0) begin
        record_error(ERR_END, pc);
        live = 1'b0;
      end else begin
        open_frames--;
        top = open_frames;
        if (fr_kind[top] == KIND_BLOCK) begin
          if (fr_entry_live[top] && live && stk_h != fr_entry_h[top]) begin
            record_error(ERR_BLOCK_H, pc);
            live = 1'b0;
          end
        end else begin
          // Merge the two arms of the if
          then_ok = fr_then_seen[top] ? fr_then_live[top] : fr_entry_live[top];
          then_h  = fr_then_seen[top] ? fr_then_h[top] : fr_entry_h[top];
          else_ok = live;
          else_h  = live ? stk_h : '0;
          if (then_ok && else_ok && then_h != else_h) begin
            record_error(ERR_IF_H, pc);
            live = 1'b0;
          end else if (then_ok) begin
            live  = 1'b1;
            stk_h = then_h;
          end else if (else_ok) begin
            live  = 1'b1;
            stk_h = else_h;
          end else begin
            live  = 1'b0;
            stk_h = fr_entry_h[top];
          end
        end
      end
    end else if (op == OP_RET) begin
      if (live) begin
        if (stk_h == 0) record_error(ERR_UNDERFLOW, pc);
        else stk_h--;
        live = 1'b0;
      end
    end else if (op > OP_HALT) begin
      record_error(ERR_BAD_OP, pc);
      live = 1'b0;
    end else if (live) begin
      case (op)
        OP_PEEK, OP_POP_A, OP_POP_B: need = 32'd1;
        OP_BIN_A, OP_BIN_B:          need = 32'd2;
        OP_CALL:                     need = {16'b0, argc} + 32'd1;
        default:                     need = 32'd0;
      endcase
      if (stk_h < need) begin
        record_error(ERR_UNDERFLOW, pc);
        live = 1'b0;
      end else if (op == OP_PUSH_A || op == OP_PUSH_B) begin
        if (stk_h != '1) stk_h++;
      end else if (op == OP_POP_A || op == OP_POP_B || op == OP_BIN_A || op == OP_BIN_B) begin
        stk_h--;
      end else if (op == OP_CALL) begin
        stk_h -= {16'b0, argc};
      end
    end
    if (live && stk_h > peak_h) peak_h = stk_h;
  endfunction

  // Advance the checker by one accepted item; a region end queues a verdict
  function automatic void track_stack(bc_item_t it);
    verdict_t v;
    case (it.req)
      REQ_START: begin
        clear_region();
        peak_h       = '0;
        first_code   = ERR_NONE;
        first_pc     = -17'sd1;
        first_region = -9'sd1;
        region_no    = '0;
      end
      REQ_INSTR: begin
        if (!region_halted) exec_instr(it.op, it.arg, it.pc);
      end
      REQ_END: begin
        if (open_frames > 0) record_error(ERR_UNCLOSED, it.pc);
        if (live && stk_h != 0) record_error(ERR_FINAL_H, saw_instr ? last_pc : it.pc);
        v.ok   = (first_code == ERR_NONE);
        v.code = first_code;
        v.epc  = first_pc;
        v.ergn = first_region;
        v.peak = sat16(peak_h);
        v.fin  = sat16(stk_h);
        verdict_q.push_back(v);
        region_no++;
        clear_region();
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------------
  int unsigned queued_items = 0;
  logic [15:0] pc_run       = '0;
  int          g_h          = 0;  // height the generator believes in
  bit          open_kind [$];
  int          open_entry[$];
  int          open_then [$];
  bit          open_else [$];

  task automatic add_item(shv_req_e r, logic [7:0] op, logic [15:0] arg, logic [15:0] pc,
                          bit hold = 1'b0);
    bc_item_t it;
    it.req  = r;
    it.op   = op;
    it.arg  = arg;
    it.pc   = pc;
    it.hold = hold;
    item_q.push_back(it);
    if (r != REQ_NONE) queued_items++;
  endtask

  task automatic emit_instr(logic [7:0] op, logic [15:0] arg);
    add_item(REQ_INSTR, op, arg, pc_run);
    pc_run++;
  endtask

  task automatic emit_op(logic [7:0] op);
    emit_instr(op, 16'($urandom_range(0, 65535)));
  endtask

  task automatic emit_end();
    add_item(REQ_END, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)), pc_run);
  endtask

  task automatic emit_start(bit hold);
    add_item(REQ_START, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
             16'($urandom_range(0, 65535)), hold);
  endtask

  task automatic set_height(int target);
    while (g_h < target) begin
      emit_op(OP_PUSH_A);
      g_h++;
    end
    while (g_h > target) begin
      emit_op(OP_POP_B);
      g_h--;
    end
  endtask

  // Balance the innermost frame and close it
  task automatic close_frame();
    int target;
    target = (open_kind[$] == KIND_IF && open_else[$]) ? open_then[$] : open_entry[$];
    set_height(target);
    emit_op(OP_END);
    void'(open_kind.pop_back());
    void'(open_entry.pop_back());
    void'(open_then.pop_back());
    void'(open_else.pop_back());
  endtask

  // One region of structured code with random content; sloppy regions carry junk
  task automatic gen_region(int n, bit sloppy);
    int argc;
    open_kind.delete();
    open_entry.delete();
    open_then.delete();
    open_else.delete();
    g_h = 0;
    repeat (n) begin
      if (sloppy && $urandom_range(0, 7) == 0) begin
        if ($urandom_range(0, 1) == 1) emit_op(8'($urandom_range(0, 14)));
        else emit_op(8'($urandom_range(0, 255)));
      end else begin
        case ($urandom_range(0, 11))
          0, 1, 2: begin
            emit_op($urandom_range(0, 1) ? OP_PUSH_A : OP_PUSH_B);
            g_h++;
          end
          3: if (g_h >= 1) begin
            emit_op($urandom_range(0, 1) ? OP_POP_A : OP_POP_B);
            g_h--;
          end
          4: if (g_h >= 2) begin
            emit_op($urandom_range(0, 1) ? OP_BIN_A : OP_BIN_B);
            g_h--;
          end
          5: if (g_h >= 1) emit_op(OP_PEEK);
          6: if (g_h >= 1) begin
            argc = $urandom_range(0, g_h - 1);
            emit_instr(OP_CALL, 16'(argc));
            g_h -= argc;
          end
          7: if (open_kind.size() < 5) begin
            emit_op(OP_SCOPE);
            open_kind.push_back(KIND_BLOCK);
            open_entry.push_back(g_h);
            open_then.push_back(0);
            open_else.push_back(1'b0);
          end
          8: if (g_h >= 1 && open_kind.size() < 5) begin
            emit_op(OP_IF);
            g_h--;
            open_kind.push_back(KIND_IF);
            open_entry.push_back(g_h);
            open_then.push_back(0);
            open_else.push_back(1'b0);
          end
          9: if (open_kind.size() > 0 && open_kind[$] == KIND_IF) begin
            // A repeated else simply re-records the then-branch
            emit_op(OP_ELSE);
            open_then[$] = g_h;
            open_else[$] = 1'b1;
            g_h = open_entry[$];
          end
          10: if (open_kind.size() > 0) close_frame();
          default: emit_op($urandom_range(0, 1) ? OP_NOP : OP_HALT);
        endcase
      end
    end
    // Close what is open, now and then leave frames or height behind
    while (open_kind.size() > 0) begin
      if (sloppy && $urandom_range(0, 5) == 0) break;
      close_frame();
    end
    if (!(sloppy && $urandom_range(0, 4) == 0)) begin
      if ($urandom_range(0, 5) == 0) begin
        set_height(1);
        emit_op(OP_RET);
      end else begin
        set_height(0);
      end
    end
    emit_end();
  endtask

  // ---------------------------------------------------------------------------
  // Clock, reset, stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("stack_height_validator_unit regression: fail");
    $finish;
  end

  initial begin
    int unsigned base;

    // Instruction before any start, an ignored request, nonzero final height
    pc_run = 16'd16;
    emit_op(OP_PUSH_A);
    add_item(REQ_NONE, 8'hFF, 16'hFFFF, 16'hFFFF);
    emit_end();
    // Field extremes: top opcode, argument and address
    emit_start(1'b0);
    pc_run = 16'hFFFF;
    emit_instr(8'hFF, 16'hFFFF);
    emit_end();
    // Every opcode, if/else merge with a repeated else, underflow on return
    emit_start(1'b1);
    pc_run = 16'hFFF0;
    emit_op(OP_PUSH_A);
    emit_op(OP_PUSH_B);
    emit_op(OP_PUSH_A);
    emit_op(OP_PEEK);
    emit_op(OP_BIN_A);
    emit_op(OP_BIN_B);
    emit_op(OP_POP_A);
    emit_op(OP_PUSH_B);
    emit_instr(OP_CALL, 16'd0);
    emit_op(OP_IF);
    emit_op(OP_NOP);
    emit_op(OP_ELSE);
    emit_op(OP_PUSH_A);
    emit_op(OP_ELSE);
    emit_op(OP_PUSH_B);
    emit_op(OP_END);
    emit_op(OP_SCOPE);
    emit_op(OP_HALT);
    emit_op(OP_END);
    emit_op(OP_POP_B);
    emit_op(OP_RET);
    emit_end();

    // Fill the control stack exactly, then overflow it in the next region
    emit_start(1'b0);
    pc_run = 16'($urandom_range(0, 65535));
    repeat (FRAMES) emit_op(OP_SCOPE);
    repeat (FRAMES) emit_op(OP_END);
    emit_end();
    repeat (FRAMES + 1) emit_op(OP_SCOPE);
    emit_op(OP_PUSH_A);
    emit_op(OP_END);
    emit_end();

    // Walk the region counter through its wrap, failing in the last region before it wraps
    emit_start(1'b0);
    repeat (255) begin
      pc_run = 16'($urandom_range(0, 65535));
      emit_end();
    end
    emit_op(OP_PUSH_B);
    emit_end();
    repeat (2) emit_end();

    // Random programs of one to three regions, with noise between them
    base = queued_items;
    while (queued_items < base + RAND_ITEMS) begin
      if ($urandom_range(0, 5) != 0) emit_start($urandom_range(0, 11) == 0);
      pc_run = 16'($urandom_range(0, 65535));
      repeat ($urandom_range(1, 3)) begin
        gen_region(($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 16),
                   $urandom_range(0, 2) == 0);
      end
      if ($urandom_range(0, 7) == 0) begin
        add_item(REQ_NONE, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                 16'($urandom_range(0, 65535)));
      end
      if ($urandom_range(0, 9) == 0) begin
        add_item(shv_req_e'($urandom_range(0, 2)), 8'($urandom_range(0, 255)),
                 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
      end
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Drain: all items sent, all verdicts seen, then a quiet stretch
    while (item_q.size() != 0 || push) @(posedge clk_i);
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
    if (fault_count == 0) begin
      $display("stack_height_validator_unit regression: pass");
    end else begin
      $display("stack_height_validator_unit regression: fail");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Driver: feed items from the pending queue with random idle bursts
  // ---------------------------------------------------------------------------
  bc_item_t cur_item;
  int       src_gap     = 0;
  bit       src_idle_on = 1'b1;
  bit       tail_phase  = 1'b0;
  logic     push_nxt;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push       <= 1'b0;
      req_type_i <= REQ_NONE;
      opcode_i   <= '0;
      arg_i      <= '0;
      pc_i       <= '0;
    end else begin
      if (push && !full) track_stack(cur_item);
      if ($urandom_range(0, 47) == 0) src_idle_on = ~src_idle_on;
      if (push && full) begin
        push_nxt = 1'b1;
      end else if (src_gap > 0) begin
        src_gap--;
        push_nxt = 1'b0;
      end else if (item_q.size() > 0 && (!item_q[0].hold || verdict_q.size() == 0)) begin
        cur_item = item_q.pop_front();
        push_nxt = 1'b1;
        tail_phase = (item_q.size() < TAIL_ITEMS);
        if (src_idle_on && !tail_phase && $urandom_range(0, 3) == 0)
          src_gap = $urandom_range(1, 16);
      end else begin
        push_nxt = 1'b0;
      end
      push       <= push_nxt;
      req_type_i <= cur_item.req;
      opcode_i   <= cur_item.op;
      arg_i      <= cur_item.arg;
      pc_i       <= cur_item.pc;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: take verdicts with random stalls and compare against the checker
  // ---------------------------------------------------------------------------
  int       snk_stall   = 0;
  bit       snk_idle_on = 1'b1;
  verdict_t want;

  task automatic report_fault(string msg);
    $display("[%0t] MISMATCH %s", $realtime, msg);
    fault_count++;
  endtask

  task automatic check_verdict();
    if (verdict_q.size() == 0) begin
      report_fault("verdict with none outstanding");
      return;
    end
    want = verdict_q.pop_front();
    if (valid_res_o !== want.ok)
      report_fault($sformatf("valid_res got %0b want %0b", valid_res_o, want.ok));
    if (error_code_o !== want.code)
      report_fault($sformatf("error_code got %0d want %0d", error_code_o, want.code));
    if (error_pc_o !== want.epc)
      report_fault($sformatf("error_pc got %0d want %0d", error_pc_o, want.epc));
    if (error_region_o !== want.ergn)
      report_fault($sformatf("error_region got %0d want %0d", error_region_o, want.ergn));
    if (peak_height_o !== want.peak)
      report_fault($sformatf("peak_height got %0d want %0d", peak_height_o, want.peak));
    if (final_height_o !== want.fin)
      report_fault($sformatf("final_height got %0d want %0d", final_height_o, want.fin));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) check_verdict();
      if ($urandom_range(0, 47) == 0) snk_idle_on = ~snk_idle_on;
      if (snk_stall > 0) begin
        snk_stall--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
        if (snk_idle_on && !tail_phase && $urandom_range(0, 3) == 0)
          snk_stall = $urandom_range(1, 16);
      end
    end
  end

endmodule

`default_nettype wire

// ===== stack_height_validator_unit.f =====
rtl/core/shv_pkg.sv
rtl/core/shv_fifo.sv
rtl/core/shv_front.sv
rtl/core/shv_back.sv
rtl/core/stack_height_validator_unit.sv
sim/tb_top.sv
